### sv/scc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scc_pkg
// Types and constants shared by the segment coordinate clipper.
// ----------------------------------------------------------------------------
package scc_pkg;

	localparam logic signed [31:0] COORD_MAX = 32'sd32767;
	localparam logic signed [31:0] COORD_MIN = -32'sd32768;

	// magnitude widths: |limit - c| and |delta| fit 33 bits, product 66 bits
	localparam int MAG_W        = 33;
	localparam int PROD_W       = 2 * MAG_W;
	localparam int DIV_BITS     = 2;
	localparam int DIV_STEPS    = PROD_W / DIV_BITS;
	localparam int QUO_W        = 32;

	typedef struct packed {
		logic signed [31:0] start_x;
		logic signed [31:0] start_y;
		logic signed [31:0] end_x;
		logic signed [31:0] end_y;
	} seg_t;

	typedef struct packed {
		logic signed [31:0] clipped_start_x;
		logic signed [31:0] clipped_start_y;
		logic signed [31:0] clipped_end_x;
		logic signed [31:0] clipped_end_y;
		logic [7:0]         clip_mask;
		logic               out_of_space;
	} res_t;

	// segment as it moves through the clip stages
	typedef struct packed {
		logic signed [31:0] x1;
		logic signed [31:0] y1;
		logic signed [31:0] x2;
		logic signed [31:0] y2;
		logic [7:0]         mask;
		logic               reject;
	} item_t;

	// item plus what the final step of a clip stage needs
	typedef struct packed {
		item_t item;
		logic  fire;
		logic  is_max;
		logic  neg;
		logic  dz;
	} side_t;

endpackage
`default_nettype wire

### sv/scc_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scc_divider
// Pipelined restoring divider, two quotient bits per stage; keeps the low
// quotient bits and carries the clip sideband alongside.
// ----------------------------------------------------------------------------
module scc_divider (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	input  wire scc_pkg::side_t             in_side,
	input  wire logic [scc_pkg::PROD_W-1:0] in_num,
	input  wire logic [scc_pkg::MAG_W-1:0]  in_den,
	output logic                            out_valid,
	output scc_pkg::side_t                  out_side,
	output logic [scc_pkg::QUO_W-1:0]       out_quo
);
	import scc_pkg::*;

	logic              valid_s [DIV_STEPS+1];
	side_t             side_s  [DIV_STEPS+1];
	logic [PROD_W-1:0] num_s   [DIV_STEPS+1];
	logic [MAG_W-1:0]  den_s   [DIV_STEPS+1];
	logic [MAG_W-1:0]  rem_s   [DIV_STEPS+1];
	logic [QUO_W-1:0]  quo_s   [DIV_STEPS+1];

	assign valid_s[0] = in_valid;
	assign side_s[0]  = in_side;
	assign num_s[0]   = in_num;
	assign den_s[0]   = in_den;
	assign rem_s[0]   = '0;
	assign quo_s[0]   = '0;

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
		logic [MAG_W:0]    r;
		logic [PROD_W-1:0] n;
		logic [QUO_W-1:0]  q;

		always_comb begin
			r = {1'b0, rem_s[i]};
			n = num_s[i];
			q = quo_s[i];
			for (int b = 0; b < DIV_BITS; b++) begin
				r = {r[MAG_W-1:0], n[PROD_W-1]};
				n = {n[PROD_W-2:0], 1'b0};
				if (r >= {1'b0, den_s[i]}) begin
					r = r - {1'b0, den_s[i]};
					q = {q[QUO_W-2:0], 1'b1};
				end else begin
					q = {q[QUO_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i+1] <= 1'b0;
			end else begin
				valid_s[i+1] <= valid_s[i];
			end
		end

		always_ff @(posedge clk) begin
			side_s[i+1] <= side_s[i];
			num_s[i+1]  <= n;
			den_s[i+1]  <= den_s[i];
			rem_s[i+1]  <= r[MAG_W-1:0];
			quo_s[i+1]  <= q;
		end
	end

	assign out_valid = valid_s[DIV_STEPS];
	assign out_side  = side_s[DIV_STEPS];
	assign out_quo   = quo_s[DIV_STEPS];

endmodule
`default_nettype wire

### sv/scc_clip_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scc_clip_stage
// One clip step: limit test, magnitudes, multiply, divide, then move the
// tested coordinate to the limit and shift the other one along the line.
// ----------------------------------------------------------------------------
module scc_clip_stage #(
	parameter bit AXIS_Y = 1'b0,
	parameter bit END_PT = 1'b0
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire scc_pkg::item_t in_item,
	output logic                out_valid,
	output scc_pkg::item_t      out_item
);
	import scc_pkg::*;

	localparam int MASK_BIT = (END_PT ? 4 : 0) + (AXIS_Y ? 2 : 0);

	logic signed [31:0]    t, op, c;
	logic                  above, below, f_max, f_min, rej;
	logic signed [MAG_W-1:0] lim, num, d_oth, d_thi;
	side_t                 side_c;

	always_comb begin
		t  = AXIS_Y ? (END_PT ? in_item.y2 : in_item.y1) : (END_PT ? in_item.x2 : in_item.x1);
		op = AXIS_Y ? in_item.y2 : in_item.x2;
		c  = AXIS_Y ? in_item.y1 : in_item.x1;
		above = t > COORD_MAX;
		below = t < COORD_MIN;
		if (END_PT) begin
			f_max = above;
			f_min = below;
			rej   = 1'b0;
		end else begin
			f_max = above && (op < COORD_MAX);
			f_min = below && (op > COORD_MIN);
			rej   = (above && !(op < COORD_MAX)) || (below && !(op > COORD_MIN));
		end
		lim = f_max ? {COORD_MAX[31], COORD_MAX} : {COORD_MIN[31], COORD_MIN};
		num = lim - {c[31], c};
		if (AXIS_Y) begin
			d_oth = {in_item.x2[31], in_item.x2} - {in_item.x1[31], in_item.x1};
			d_thi = {in_item.y2[31], in_item.y2} - {in_item.y1[31], in_item.y1};
		end else begin
			d_oth = {in_item.y2[31], in_item.y2} - {in_item.y1[31], in_item.y1};
			d_thi = {in_item.x2[31], in_item.x2} - {in_item.x1[31], in_item.x1};
		end
		side_c        = '0;
		side_c.item   = in_item;
		side_c.fire   = !in_item.reject && (f_max || f_min);
		side_c.is_max = f_max;
		side_c.neg    = num[MAG_W-1] ^ d_oth[MAG_W-1] ^ d_thi[MAG_W-1];
		side_c.dz     = d_thi == '0;
		side_c.item.reject = in_item.reject || rej;
	end

	// s1: test and magnitudes
	logic             valid_s1, valid_s2;
	side_t            side_s1, side_s2;
	logic [MAG_W-1:0] a_s1, b_s1, d_s1, d_s2;
	logic [PROD_W-1:0] prod_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		side_s1 <= side_c;
		a_s1    <= num[MAG_W-1] ? MAG_W'(-num) : MAG_W'(num);
		b_s1    <= d_oth[MAG_W-1] ? MAG_W'(-d_oth) : MAG_W'(d_oth);
		d_s1    <= d_thi[MAG_W-1] ? MAG_W'(-d_thi) : MAG_W'(d_thi);
		side_s2 <= side_s1;
		prod_s2 <= PROD_W'(a_s1) * PROD_W'(b_s1);
		d_s2    <= d_s1;
	end

	logic             dv_valid;
	side_t            dv_side;
	logic [QUO_W-1:0] dv_quo;

	scc_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s2),
		.in_side  (side_s2),
		.in_num   (prod_s2),
		.in_den   (d_s2),
		.out_valid(dv_valid),
		.out_side (dv_side),
		.out_quo  (dv_quo)
	);

	logic [31:0]        q, base;
	logic signed [31:0] lim32, moved;
	item_t              item_c;

	always_comb begin
		q     = dv_side.dz ? 32'd0 : dv_quo;
		q     = dv_side.neg ? (32'd0 - q) : q;
		base  = AXIS_Y ? dv_side.item.x1 : dv_side.item.y1;
		moved = $signed(base + q);
		lim32 = dv_side.is_max ? COORD_MAX : COORD_MIN;
		item_c = dv_side.item;
		if (dv_side.fire) begin
			unique case ({END_PT, AXIS_Y})
				2'b00: begin item_c.x1 = lim32; item_c.y1 = moved; end
				2'b01: begin item_c.y1 = lim32; item_c.x1 = moved; end
				2'b10: begin item_c.x2 = lim32; item_c.y2 = moved; end
				default: begin item_c.y2 = lim32; item_c.x2 = moved; end
			endcase
			item_c.mask[MASK_BIT + (dv_side.is_max ? 0 : 1)] = 1'b1;
		end
	end

	// s3: apply the shift
	logic  valid_s3;
	item_t item_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		item_s3 <= item_c;
	end

	assign out_valid = valid_s3;
	assign out_item  = item_s3;

endmodule
`default_nettype wire

### sv/segment_coordinate_clipper_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// segment_coordinate_clipper_core
// Clips a segment to the signed 16-bit coordinate range in four ordered
// steps (start x, start y, end x, end y) and flags rejected segments.
//
//  channel  ports             handshake
//  input    segment           transfer when start && !busy
//  output   result            transfer on done, one cycle, cannot be held
//
// One segment per cycle; busy stays low. Each of the four clip steps is
// registered as test, multiply, a 33-stage divider at two quotient bits per
// stage, then apply; one output register follows.
// Reset clears only the valid bits. There are no stalls.
// ----------------------------------------------------------------------------
module segment_coordinate_clipper_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire scc_pkg::seg_t segment,
	output logic               done,
	output scc_pkg::res_t      result
);
	import scc_pkg::*;

	logic  v [5];
	item_t it [5];

	assign busy  = 1'b0;
	assign v[0]  = start;
	assign it[0] = '{x1: segment.start_x, y1: segment.start_y,
			x2: segment.end_x, y2: segment.end_y, mask: 8'd0, reject: 1'b0};

	scc_clip_stage #(.AXIS_Y(1'b0), .END_PT(1'b0)) u_sx (
		.clk(clk), .arst_n(arst_n), .in_valid(v[0]), .in_item(it[0]),
		.out_valid(v[1]), .out_item(it[1]));
	scc_clip_stage #(.AXIS_Y(1'b1), .END_PT(1'b0)) u_sy (
		.clk(clk), .arst_n(arst_n), .in_valid(v[1]), .in_item(it[1]),
		.out_valid(v[2]), .out_item(it[2]));
	scc_clip_stage #(.AXIS_Y(1'b0), .END_PT(1'b1)) u_ex (
		.clk(clk), .arst_n(arst_n), .in_valid(v[2]), .in_item(it[2]),
		.out_valid(v[3]), .out_item(it[3]));
	scc_clip_stage #(.AXIS_Y(1'b1), .END_PT(1'b1)) u_ey (
		.clk(clk), .arst_n(arst_n), .in_valid(v[3]), .in_item(it[3]),
		.out_valid(v[4]), .out_item(it[4]));

	logic done_q;
	res_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v[4];
		end
	end

	always_ff @(posedge clk) begin
		if (it[4].reject) begin
			res_q <= '{clipped_start_x: 32'sd0, clipped_start_y: 32'sd0,
				clipped_end_x: 32'sd0, clipped_end_y: 32'sd0,
				clip_mask: 8'd0, out_of_space: 1'b1};
		end else begin
			res_q <= '{clipped_start_x: it[4].x1, clipped_start_y: it[4].y1,
				clipped_end_x: it[4].x2, clipped_end_y: it[4].y2,
				clip_mask: it[4].mask, out_of_space: 1'b0};
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule
`default_nettype wire

### bench/tb_segment_coordinate_clipper_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_segment_coordinate_clipper_core
// Drives directed and random segments into the clipper and compares every result
// against a fixed value (some directed rows) or a predictor that clips it the same
// way in four ordered steps, using exact quotients truncated toward zero.
// ----------------------------------------------------------------------------
module tb_segment_coordinate_clipper_core;
	import scc_pkg::*;

	localparam int LATENCY = 145;
	localparam int N_RANDOM = 700;
	localparam longint CYCLE_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	seg_t segment = '0;
	logic done;
	res_t result;

	res_t expected_results[$];
	int errors = 0;
	longint cycle_count = 0;

	typedef struct {
		seg_t seg;
		logic has_res;
		res_t res;
	} row_t;

	segment_coordinate_clipper_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.segment(segment), .done(done), .result(result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// trunc(a*b/c) wrapped into base; zero divisor gives zero shift
	function automatic logic signed [31:0] slide(longint base, longint limit,
		longint c, longint d_other, longint d_this);
		logic signed [127:0] num;
		logic signed [127:0] quo;
		begin
			if (d_this == 0)
				quo = 0;
			else begin
				num = 128'(signed'(limit - c)) * 128'(signed'(d_other));
				quo = num / 128'(signed'(d_this));
			end
			slide = 32'(128'(signed'(base)) + quo);
		end
	endfunction

	function automatic res_t clip_segment(seg_t s);
		longint x1, y1, x2, y2;
		logic [7:0] m;
		logic rej;
		res_t r;
		begin
			x1 = s.start_x; y1 = s.start_y; x2 = s.end_x; y2 = s.end_y;
			m = '0;
			rej = 1'b0;
			if (x1 > COORD_MAX) begin
				if (x2 < COORD_MAX) begin
					y1 = slide(y1, COORD_MAX, x1, y2 - y1, x2 - x1);
					x1 = COORD_MAX; m |= 8'd1;
				end else rej = 1'b1;
			end else if (x1 < COORD_MIN) begin
				if (x2 > COORD_MIN) begin
					y1 = slide(y1, COORD_MIN, x1, y2 - y1, x2 - x1);
					x1 = COORD_MIN; m |= 8'd2;
				end else rej = 1'b1;
			end
			if (!rej) begin
				if (y1 > COORD_MAX) begin
					if (y2 < COORD_MAX) begin
						x1 = slide(x1, COORD_MAX, y1, x2 - x1, y2 - y1);
						y1 = COORD_MAX; m |= 8'd4;
					end else rej = 1'b1;
				end else if (y1 < COORD_MIN) begin
					if (y2 > COORD_MIN) begin
						x1 = slide(x1, COORD_MIN, y1, x2 - x1, y2 - y1);
						y1 = COORD_MIN; m |= 8'd8;
					end else rej = 1'b1;
				end
			end
			if (!rej) begin
				// end point shifts are based on the start point's coordinate
				if (x2 > COORD_MAX) begin
					y2 = slide(y1, COORD_MAX, x1, y2 - y1, x2 - x1);
					x2 = COORD_MAX; m |= 8'd16;
				end else if (x2 < COORD_MIN) begin
					y2 = slide(y1, COORD_MIN, x1, y2 - y1, x2 - x1);
					x2 = COORD_MIN; m |= 8'd32;
				end
				if (y2 > COORD_MAX) begin
					x2 = slide(x1, COORD_MAX, y1, x2 - x1, y2 - y1);
					y2 = COORD_MAX; m |= 8'd64;
				end else if (y2 < COORD_MIN) begin
					x2 = slide(x1, COORD_MIN, y1, x2 - x1, y2 - y1);
					y2 = COORD_MIN; m |= 8'd128;
				end
			end
			r = '0;
			if (rej)
				r.out_of_space = 1'b1;
			else begin
				r.clipped_start_x = 32'(x1);
				r.clipped_start_y = 32'(y1);
				r.clipped_end_x = 32'(x2);
				r.clipped_end_y = 32'(y2);
				r.clip_mask = m;
			end
			clip_segment = r;
		end
	endfunction

	// mostly near the 16-bit limits, sometimes anywhere in 32 bits
	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: rand_coord = $urandom;
			1: rand_coord = 32'(int'($urandom_range(0, 131071)) - 65536);
			2: rand_coord = 32'(int'($urandom_range(0, 8)) + 32763);
			3: rand_coord = 32'(int'($urandom_range(0, 8)) - 32772);
			4: rand_coord = 32'(int'($urandom_range(0, 65535)) - 32768);
			default: rand_coord = $urandom_range(0, 1) ? 32'h7fffffff - $urandom_range(0, 3)
				: 32'h80000000 + $urandom_range(0, 3);
		endcase
	endfunction

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// result checker
	always @(posedge clk) begin
		res_t exp_r;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result transfer");
				errors++;
			end else begin
				exp_r = expected_results.pop_front();
				if (result.clipped_start_x !== exp_r.clipped_start_x) begin
					$error("clipped_start_x exp %0d got %0d", exp_r.clipped_start_x,
						result.clipped_start_x);
					errors++;
				end
				if (result.clipped_start_y !== exp_r.clipped_start_y) begin
					$error("clipped_start_y exp %0d got %0d", exp_r.clipped_start_y,
						result.clipped_start_y);
					errors++;
				end
				if (result.clipped_end_x !== exp_r.clipped_end_x) begin
					$error("clipped_end_x exp %0d got %0d", exp_r.clipped_end_x,
						result.clipped_end_x);
					errors++;
				end
				if (result.clipped_end_y !== exp_r.clipped_end_y) begin
					$error("clipped_end_y exp %0d got %0d", exp_r.clipped_end_y,
						result.clipped_end_y);
					errors++;
				end
				if (result.clip_mask !== exp_r.clip_mask) begin
					$error("clip_mask exp %0h got %0h", exp_r.clip_mask, result.clip_mask);
					errors++;
				end
				if (result.out_of_space !== exp_r.out_of_space) begin
					$error("out_of_space exp %0b got %0b", exp_r.out_of_space,
						result.out_of_space);
					errors++;
				end
			end
		end
	end

	// one transfer; gap cycles before it with start low
	task automatic send_segment(seg_t s, res_t exp_r, int gap);
		begin
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			start <= 1'b1;
			segment <= s;
			@(posedge clk);
			while (busy) @(posedge clk);
			expected_results.push_back(exp_r);
		end
	endtask

	row_t rows[$];
	row_t rw;
	res_t z;

	function automatic row_t mk(int sx, int sy, int ex, int ey, logic has, res_t r);
		row_t t;
		begin
			t.seg = '{sx, sy, ex, ey};
			t.has_res = has;
			t.res = r;
			mk = t;
		end
	endfunction

	function automatic res_t rs(int a, int b, int c, int d, logic [7:0] m, logic o);
		res_t r;
		begin
			r = '{a, b, c, d, m, o};
			rs = r;
		end
	endfunction

	initial begin
		seg_t s;
		int gap;
		z = '0;
		rows.push_back(mk(0, 0, 0, 0, 1, rs(0, 0, 0, 0, 8'd0, 0)));
		rows.push_back(mk(32767, -32768, -32768, 32767, 1,
			rs(32767, -32768, -32768, 32767, 8'd0, 0)));
		// start beyond a limit, end not strictly inside: rejected
		rows.push_back(mk(40000, 0, 32767, 0, 1, rs(0, 0, 0, 0, 8'd0, 1)));
		rows.push_back(mk(-40000, 0, -40000, 0, 1, rs(0, 0, 0, 0, 8'd0, 1)));
		rows.push_back(mk(0, 40000, 0, 50000, 1, rs(0, 0, 0, 0, 8'd0, 1)));
		rows.push_back(mk(0, -40000, 5, -32768, 1, rs(0, 0, 0, 0, 8'd0, 1)));
		rows.push_back(mk(32'h7fffffff, 0, 32'h7fffffff, 0, 1, rs(0, 0, 0, 0, 8'd0, 1)));
		rows.push_back(mk(32'h80000000, 32'h80000000, 32'h80000000, 5, 1,
			rs(0, 0, 0, 0, 8'd0, 1)));
		// end-only clips with zero delta in the other axis
		rows.push_back(mk(0, 0, 40000, 0, 1, rs(0, 0, 32767, 0, 8'd16, 0)));
		rows.push_back(mk(0, 0, -40000, 0, 1, rs(0, 0, -32768, 0, 8'd32, 0)));
		rows.push_back(mk(0, 0, 0, 40000, 1, rs(0, 0, 0, 32767, 8'd64, 0)));
		rows.push_back(mk(0, 0, 0, -40000, 1, rs(0, 0, 0, -32768, 8'd128, 0)));
		// start clips, one per bit, and a diagonal
		rows.push_back(mk(40000, 0, 0, 0, 0, z));
		rows.push_back(mk(-40000, 7, 0, -3, 0, z));
		rows.push_back(mk(3, 40000, 0, 0, 0, z));
		rows.push_back(mk(-9, -40000, 0, 0, 0, z));
		rows.push_back(mk(100000, 100000, -100000, -100000, 0, z));
		// x clip with dy=0 leaves start y beyond the limit with end y: rejected
		rows.push_back(mk(40000, 50000, 0, 50000, 0, z));
		// huge spans exercise the wide product and wrap
		rows.push_back(mk(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff, 0, z));
		rows.push_back(mk(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 0, z));
		rows.push_back(mk(-1, -1, 32'h7fffffff, 32'h80000001, 0, z));
		rows.push_back(mk(32'h7ffffffe, 3, -32767, 32'h7fffffff, 0, z));
		rows.push_back(mk(32768, -32769, -32769, 32768, 0, z));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			rw = rows[i];
			send_segment(rw.seg, rw.has_res ? rw.res : clip_segment(rw.seg),
				(i % 3 == 0) ? 0 : $urandom_range(0, 6));
		end

		for (int n = 0; n < N_RANDOM; n++) begin
			s = '{rand_coord(), rand_coord(), rand_coord(), rand_coord()};
			// stretches with no gaps between bursts with random gaps
			gap = ((n / 50) % 2 == 0) ? 0 : $urandom_range(0, 6);
			if (n == N_RANDOM / 2) begin
				start <= 1'b0;
				while (expected_results.size() != 0) @(posedge clk);
			end
			send_segment(s, clip_segment(s), gap);
		end
		start <= 1'b0;

		while (expected_results.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
`default_nettype wire

### filelist.f
sv/scc_pkg.sv
sv/scc_divider.sv
sv/scc_clip_stage.sv
sv/segment_coordinate_clipper_core.sv
bench/tb_segment_coordinate_clipper_core.sv
